/* src/timed_color_step_sequencer_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the timed color step sequencer
// Property forms used by the sequencer control module.
// ----------------------------------------------------------------------------
`ifndef TIMED_COLOR_STEP_SEQUENCER_ASSERT_SVH
`define TIMED_COLOR_STEP_SEQUENCER_ASSERT_SVH

// The consequence must hold in the same cycle as the condition.
`define TCSS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequence must hold in the cycle after the condition.
`define TCSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/tcss_pkg.sv */
// ----------------------------------------------------------------------------
// tcss_pkg
// Types, constants and helper functions shared by the sequencer modules.
// ----------------------------------------------------------------------------
package tcss_pkg;

   // Table sizes.
   localparam int MAX_STEPS = 8;
   localparam int MAX_LEDS  = 8;

   // Field widths.
   localparam int STEP_W  = 3;
   localparam int SLOT_W  = 3;
   localparam int COUNT_W = 4;
   localparam int CHAN_W  = 8;
   localparam int MS_W    = 32;
   localparam int LED_W   = 16;
   localparam int REG_W   = 2;

   // Operation codes of an input item.
   typedef enum logic [1:0] {
      OP_TICK       = 2'd0,
      OP_START      = 2'd1,
      OP_WRITE_STEP = 2'd2,
      OP_WRITE_LED  = 2'd3
   } op_type;

   // Configuration register indexes.
   typedef logic [REG_W-1:0] reg_index_type;
   localparam reg_index_type REG_STEPS_IN_USE = 2'd0;
   localparam reg_index_type REG_LEDS_IN_USE  = 2'd1;
   localparam reg_index_type REG_FADE_TIME    = 2'd2;

   // One word of the step memory.
   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [MS_W-1:0]   duration_ms;
   } step_entry_type;

   // Effective configuration, counts already clamped to the table sizes.
   typedef struct packed {
      logic [COUNT_W-1:0] steps;
      logic [COUNT_W-1:0] leds;
      logic [MS_W-1:0]    fade_ms;
   } cfg_type;

   // Access requests toward the step memory.
   typedef struct packed {
      logic               wr_en;
      logic [SLOT_W-1:0]  wr_addr;
      step_entry_type     wr_data;
      logic [SLOT_W-1:0]  rd_addr;
   } step_mem_req_type;

   // Access requests toward the LED memory.
   typedef struct packed {
      logic               wr_en;
      logic [SLOT_W-1:0]  wr_addr;
      logic [LED_W-1:0]   wr_data;
      logic [SLOT_W-1:0]  rd_addr;
   } led_mem_req_type;

   // Clamp a count to a maximum.
   function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] value,
                                                      input logic [COUNT_W-1:0] limit);
      clamp_count = (value > limit) ? limit : value;
   endfunction

   // Next step index, wrapping modulo the step count. The incremented value
   // is at most MAX_STEPS, so at most MAX_STEPS subtractions are needed.
   function automatic logic [STEP_W-1:0] next_step(input logic [STEP_W-1:0]  cur,
                                                   input logic [COUNT_W-1:0] steps);
      logic [COUNT_W-1:0] v;
      v = COUNT_W'(cur) + COUNT_W'(1);
      for (int k = 0; k < MAX_STEPS; k++) begin
         if (steps != '0 && v >= steps) begin
            v = v - steps;
         end
      end
      next_step = v[STEP_W-1:0];
   endfunction

endpackage

/* src/tcss_if.sv */
// ----------------------------------------------------------------------------
// Sequencer channel interfaces
// Request, response and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------

// Input items: table writes, start and tick.
interface tcss_req_if;
   import tcss_pkg::*;

   logic                valid;
   logic                ready;
   op_type              operation;
   logic [MS_W-1:0]     tick_ms;
   logic [SLOT_W-1:0]   entry_slot;
   logic [CHAN_W-1:0]   entry_red;
   logic [CHAN_W-1:0]   entry_green;
   logic [CHAN_W-1:0]   entry_blue;
   logic [MS_W-1:0]     entry_duration_ms;
   logic [LED_W-1:0]    entry_led;

   modport source (output valid, operation, tick_ms, entry_slot, entry_red, entry_green,
                   entry_blue, entry_duration_ms, entry_led, input ready);
   modport sink (input valid, operation, tick_ms, entry_slot, entry_red, entry_green,
                 entry_blue, entry_duration_ms, entry_led, output ready);
endinterface

// Result items: one LED drive command per transfer.
interface tcss_rsp_if;
   import tcss_pkg::*;

   logic                valid;
   logic                ready;
   logic [LED_W-1:0]    led_number;
   logic [CHAN_W-1:0]   out_red;
   logic [CHAN_W-1:0]   out_green;
   logic [CHAN_W-1:0]   out_blue;
   logic [MS_W-1:0]     fade_ms;
   logic [STEP_W-1:0]   step_number;
   logic                last;

   modport source (output valid, led_number, out_red, out_green, out_blue, fade_ms,
                   step_number, last, input ready);
   modport sink (input valid, led_number, out_red, out_green, out_blue, fade_ms,
                 step_number, last, output ready);
endinterface

// Configuration register writes.
interface tcss_csr_if;
   import tcss_pkg::*;

   logic                valid;
   logic                ready;
   reg_index_type       reg_index;
   logic [MS_W-1:0]     wr_data;

   modport source (output valid, reg_index, wr_data, input ready);
   modport sink (input valid, reg_index, wr_data, output ready);
endinterface

/* src/tcss_ram.sv */
// ----------------------------------------------------------------------------
// tcss_ram
// Generic memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module tcss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and read; a read of the entry written in the same cycle sees old data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/tcss_csr.sv */
// ----------------------------------------------------------------------------
// tcss_csr
// Configuration registers with count clamping.
// ----------------------------------------------------------------------------
module tcss_csr (
   input  logic               clock,
   input  logic               reset,
   tcss_csr_if.sink           csr,
   output tcss_pkg::cfg_type  cfg
);
   import tcss_pkg::*;

   logic [COUNT_W-1:0] steps_ff, steps_in;
   logic [COUNT_W-1:0] leds_ff, leds_in;
   logic [MS_W-1:0]    fade_ff, fade_in;
   logic               wr_fire;

   // Writes are always taken.
   assign csr.ready = 1'b1;
   assign wr_fire   = csr.valid & csr.ready;

   // Register decode; unknown indexes are dropped.
   always_comb begin
      steps_in = steps_ff;
      leds_in  = leds_ff;
      fade_in  = fade_ff;
      if (wr_fire) begin
         case (csr.reg_index)
            REG_STEPS_IN_USE: steps_in = csr.wr_data[COUNT_W-1:0];
            REG_LEDS_IN_USE:  leds_in  = csr.wr_data[COUNT_W-1:0];
            REG_FADE_TIME:    fade_in  = csr.wr_data;
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= COUNT_W'(1);
         leds_ff  <= COUNT_W'(1);
         fade_ff  <= '0;
      end else begin
         steps_ff <= steps_in;
         leds_ff  <= leds_in;
         fade_ff  <= fade_in;
      end
   end

   // Counts above the table sizes act as the table size.
   assign cfg.steps   = clamp_count(steps_ff, COUNT_W'(MAX_STEPS));
   assign cfg.leds    = clamp_count(leds_ff, COUNT_W'(MAX_LEDS));
   assign cfg.fade_ms = fade_ff;

endmodule

/* src/tcss_ctrl.sv */
// ----------------------------------------------------------------------------
// tcss_ctrl
// Sequencer control: reads step and LED entries, advances the step and
// issues drive commands through an output register.
// ----------------------------------------------------------------------------
`include "timed_color_step_sequencer_assert.svh"

module tcss_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  tcss_pkg::cfg_type           cfg,
   tcss_req_if.sink                    req,
   tcss_rsp_if.source                  rsp,
   output tcss_pkg::step_mem_req_type  step_mem,
   input  tcss_pkg::step_entry_type    step_rd_data,
   output tcss_pkg::led_mem_req_type   led_mem,
   input  logic [tcss_pkg::LED_W-1:0]  led_rd_data
);
   import tcss_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EVAL,
      S_EMIT,
      S_MOVE
   } state_type;

   state_type           state_ff, state_in;
   logic [STEP_W-1:0]   cur_ff, cur_in;
   logic [MS_W-1:0]     elapsed_ff, elapsed_in;
   logic [COUNT_W-1:0]  moves_ff, moves_in;
   logic [SLOT_W-1:0]   idx_ff, idx_in;
   logic                pending_ff, pending_in;
   logic                more_ff, more_in;
   logic [3*CHAN_W-1:0] color_ff, color_in;
   logic [MS_W-1:0]     dur_ff, dur_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [LED_W-1:0]    led_number_ff, led_number_in;
   logic [CHAN_W-1:0]   red_ff, red_in;
   logic [CHAN_W-1:0]   green_ff, green_in;
   logic [CHAN_W-1:0]   blue_ff, blue_in;
   logic [MS_W-1:0]     fade_ff, fade_in;
   logic [STEP_W-1:0]   step_number_ff, step_number_in;
   logic                last_ff, last_in;

   logic                req_fire;
   logic                out_free;
   logic                more_now;
   logic                last_led;
   logic                out_load;

   // Items are taken only between sequences; the output register may still hold
   // a command that waits for its transfer.
   assign req.ready = (state_ff == S_IDLE);
   assign req_fire  = req.valid & req.ready;
   assign out_free  = ~rsp_valid_ff | rsp.ready;

   // Another move follows when the move budget allows and the step read back
   // from memory has expired or has zero duration.
   assign more_now = (moves_ff < cfg.steps) &&
                     ((step_rd_data.duration_ms == '0) ||
                      (elapsed_ff >= step_rd_data.duration_ms));
   assign last_led = (COUNT_W'(idx_ff) == (cfg.leds - COUNT_W'(1)));
   assign out_load = (state_ff == S_EMIT) && out_free;

   // Next state and datapath.
   always_comb begin
      state_in       = state_ff;
      cur_in         = cur_ff;
      elapsed_in     = elapsed_ff;
      moves_in       = moves_ff;
      idx_in         = idx_ff;
      pending_in     = pending_ff;
      more_in        = more_ff;
      color_in       = color_ff;
      dur_in         = dur_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp.ready;
      led_number_in  = led_number_ff;
      red_in         = red_ff;
      green_in       = green_ff;
      blue_in        = blue_ff;
      fade_in        = fade_ff;
      step_number_in = step_number_ff;
      last_in        = last_ff;

      step_mem.wr_en   = 1'b0;
      step_mem.wr_addr = req.entry_slot;
      step_mem.wr_data = '{red: req.entry_red, green: req.entry_green,
                           blue: req.entry_blue, duration_ms: req.entry_duration_ms};
      led_mem.wr_en    = 1'b0;
      led_mem.wr_addr  = req.entry_slot;
      led_mem.wr_data  = req.entry_led;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req.operation)
                  OP_TICK: begin
                     if (cfg.steps != '0) begin
                        elapsed_in = elapsed_ff + req.tick_ms;
                        moves_in   = '0;
                        pending_in = 1'b0;
                        state_in   = S_EVAL;
                     end
                  end
                  OP_START: begin
                     cur_in     = '0;
                     elapsed_in = '0;
                     if (cfg.steps != '0) begin
                        // A full move budget means no move follows the drive.
                        moves_in   = cfg.steps;
                        pending_in = 1'b1;
                        state_in   = S_EVAL;
                     end
                  end
                  OP_WRITE_STEP: begin
                     step_mem.wr_en = (COUNT_W'(req.entry_slot) < COUNT_W'(MAX_STEPS));
                  end
                  OP_WRITE_LED: begin
                     led_mem.wr_en = (COUNT_W'(req.entry_slot) < COUNT_W'(MAX_LEDS));
                  end
                  default: ;
               endcase
            end
         end

         S_EVAL: begin
            // Step entry of the current step is now on the read port.
            color_in   = {step_rd_data.red, step_rd_data.green, step_rd_data.blue};
            dur_in     = step_rd_data.duration_ms;
            more_in    = more_now;
            idx_in     = '0;
            pending_in = 1'b0;
            if (pending_ff && cfg.leds != '0) begin
               state_in = S_EMIT;
            end else if (more_now) begin
               state_in = S_MOVE;
            end else begin
               state_in = S_IDLE;
            end
         end

         S_EMIT: begin
            // One command per LED; the LED entry is read ahead at the next LED index.
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               led_number_in  = led_rd_data;
               red_in         = color_ff[3*CHAN_W-1:2*CHAN_W];
               green_in       = color_ff[2*CHAN_W-1:CHAN_W];
               blue_in        = color_ff[CHAN_W-1:0];
               fade_in        = cfg.fade_ms;
               step_number_in = cur_ff;
               last_in        = last_led & ~more_ff;
               idx_in         = idx_ff + SLOT_W'(1);
               if (last_led) begin
                  state_in = more_ff ? S_MOVE : S_IDLE;
               end
            end
         end

         S_MOVE: begin
            if (dur_ff != '0) begin
               elapsed_in = elapsed_ff - dur_ff;
            end
            cur_in     = next_step(cur_ff, cfg.steps);
            moves_in   = moves_ff + COUNT_W'(1);
            pending_in = 1'b1;
            state_in   = S_EVAL;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Reads follow the next step and LED index, ready once those are current.
      step_mem.rd_addr = cur_in;
      led_mem.rd_addr  = idx_in;
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_ff       <= '0;
         elapsed_ff   <= '0;
         moves_ff     <= '0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         elapsed_ff   <= elapsed_in;
         moves_ff     <= moves_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff         <= idx_in;
      more_ff        <= more_in;
      color_ff       <= color_in;
      dur_ff         <= dur_in;
      led_number_ff  <= led_number_in;
      red_ff         <= red_in;
      green_ff       <= green_in;
      blue_ff        <= blue_in;
      fade_ff        <= fade_in;
      step_number_ff <= step_number_in;
      last_ff        <= last_in;
   end

   // Response payload from the output register.
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.led_number  = led_number_ff;
   assign rsp.out_red     = red_ff;
   assign rsp.out_green   = green_ff;
   assign rsp.out_blue    = blue_ff;
   assign rsp.fade_ms     = fade_ff;
   assign rsp.step_number = step_number_ff;
   assign rsp.last        = last_ff;

   // A command flagged last ends the sequence.
   `TCSS_ASSERT_NEXT(a_last_ends, clock, reset, out_load && last_in, state_ff == S_IDLE,
      "last command loaded but sequence continues")
   // A move always lands on a step inside the loop.
   `TCSS_ASSERT_NEXT(a_move_in_range, clock, reset, state_ff == S_MOVE && cfg.steps != '0,
      COUNT_W'(cur_ff) < $past(cfg.steps), "step index outside the loop after a move")
   // Each move counts exactly once.
   `TCSS_ASSERT_NEXT(a_move_count, clock, reset, state_ff == S_MOVE,
      moves_ff == $past(moves_ff) + COUNT_W'(1), "move counter did not advance")
   // No new item is taken while commands are still being produced.
   `TCSS_ASSERT_SAME(a_no_accept_busy, clock, reset, state_ff == S_EMIT,
      !req_fire && !step_mem.wr_en && !led_mem.wr_en, "table access during emission")

endmodule

/* src/timed_color_step_sequencer.sv */
// ----------------------------------------------------------------------------
// timed_color_step_sequencer
// Plays a looping table of color steps on a group of LEDs.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Carries
//   req_chan  in         tick, start, step entry write, LED entry write
//   rsp_chan  out        one LED drive command per transfer, last flagged
//   csr_chan  in         configuration register writes
//
// A start passes the evaluate state and emits one command per LED; a tick
// passes the evaluate state and then, per move, the move and evaluate states,
// emitting one command per LED. Commands leave at one per cycle while the
// response side takes them, bound by the single LED memory read port and the
// step memory read that each move needs. Reset clears the step position and
// elapsed time; table contents are undefined until written. A stalled
// response holds the sequencer in place without losing commands.
// ----------------------------------------------------------------------------
module timed_color_step_sequencer (
   input  logic       clock,
   input  logic       reset,
   tcss_req_if.sink   req_chan,
   tcss_rsp_if.source rsp_chan,
   tcss_csr_if.sink   csr_chan
);
   import tcss_pkg::*;

   cfg_type          cfg;
   step_mem_req_type step_mem;
   step_entry_type   step_rd_data;
   led_mem_req_type  led_mem;
   logic [LED_W-1:0] led_rd_data;

   // Configuration registers.
   tcss_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_chan),
      .cfg   (cfg)
   );

   // Step colors and durations.
   tcss_ram #(
      .WIDTH ($bits(step_entry_type)),
      .DEPTH (MAX_STEPS)
   ) u_step_ram (
      .clock   (clock),
      .wr_en   (step_mem.wr_en),
      .wr_addr (step_mem.wr_addr),
      .wr_data (step_mem.wr_data),
      .rd_addr (step_mem.rd_addr),
      .rd_data (step_rd_data)
   );

   // LED numbers.
   tcss_ram #(
      .WIDTH (LED_W),
      .DEPTH (MAX_LEDS)
   ) u_led_ram (
      .clock   (clock),
      .wr_en   (led_mem.wr_en),
      .wr_addr (led_mem.wr_addr),
      .wr_data (led_mem.wr_data),
      .rd_addr (led_mem.rd_addr),
      .rd_data (led_rd_data)
   );

   // Sequencer control.
   tcss_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .req          (req_chan),
      .rsp          (rsp_chan),
      .step_mem     (step_mem),
      .step_rd_data (step_rd_data),
      .led_mem      (led_mem),
      .led_rd_data  (led_rd_data)
   );

endmodule

/* sim/timed_color_step_sequencer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_color_step_sequencer_tb
// Self-checking bench for the color step sequencer. A behavioral predictor
// tracks the step position, elapsed time, tables and registers. It queues
// the LED drive commands that each accepted item should produce, and every
// response transfer is compared against the oldest queued command. Directed
// cases cover the table extremes, the zero and saturated counts, elapsed
// time wrap and the per-tick move limit. Random phases follow under several
// register settings, with random gaps on both channels and one long response
// hold-off.
// ----------------------------------------------------------------------------
module timed_color_step_sequencer_tb;
   import tcss_pkg::*;

   localparam int MAX_WAIT       = 18;
   localparam int SETTLE_CYCLES  = 100;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_LIMIT   = 10;
   localparam reg_index_type REG_SPARE = 2'd3;

   typedef struct {
      op_type             op;
      bit [MS_W-1:0]      tick_ms;
      bit [SLOT_W-1:0]    slot;
      bit [CHAN_W-1:0]    red;
      bit [CHAN_W-1:0]    green;
      bit [CHAN_W-1:0]    blue;
      bit [MS_W-1:0]      duration_ms;
      bit [LED_W-1:0]     led;
   } pattern_item_type;

   typedef struct {
      bit [LED_W-1:0]     led;
      bit [CHAN_W-1:0]    red;
      bit [CHAN_W-1:0]    green;
      bit [CHAN_W-1:0]    blue;
      bit [MS_W-1:0]      fade_ms;
      bit [STEP_W-1:0]    step_number;
      bit                 last;
   } led_command_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tcss_req_if req_chan();
   tcss_rsp_if rsp_chan();
   tcss_csr_if csr_chan();

   timed_color_step_sequencer i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Predicted registers, position and tables.
   bit [COUNT_W-1:0] steps_reg   = 4'd1;
   bit [COUNT_W-1:0] leds_reg    = 4'd1;
   bit [MS_W-1:0]    fade_reg    = '0;
   bit [STEP_W-1:0]  cur_step    = '0;
   bit [MS_W-1:0]    elapsed_sum = '0;
   bit [3*CHAN_W-1:0] color_tbl    [MAX_STEPS];
   bit [MS_W-1:0]     duration_tbl [MAX_STEPS];
   bit [LED_W-1:0]    led_tbl      [MAX_LEDS];

   // Commands still owed by the sequencer, oldest first. The newest predicted
   // command is held back until it is known whether it closes its item.
   led_command_type expected_cmds [$];
   led_command_type staged_cmd;
   bit              staged_valid = 1'b0;
   led_command_type want_cmd;

   int mismatches       = 0;
   int idle_cycles      = 0;
   int rsp_hold_request = 0;
   int send_calm        = 0;
   int recv_calm        = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Per-item wait on either side: mostly random up to MAX_WAIT, with gapless runs.
   function automatic int pick_wait(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm_left = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, MAX_WAIT);
   endfunction

   function automatic void note_mismatch(input string what);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         $display("mismatch at %0t: %s", $realtime, what);
      end
   endfunction

   function automatic void check_field(input string name, input logic [MS_W-1:0] want,
                                       input logic [MS_W-1:0] got);
      if (got !== want) begin
         note_mismatch($sformatf("%s expected %0h got %0h", name, want, got));
      end
   endfunction

   function automatic int active_steps();
      return (steps_reg > MAX_STEPS) ? MAX_STEPS : int'(steps_reg);
   endfunction

   function automatic int active_leds();
      return (leds_reg > MAX_LEDS) ? MAX_LEDS : int'(leds_reg);
   endfunction

   // One drive command per LED in use, all carrying the current step color.
   function automatic void stage_step_drive();
      led_command_type cmd;
      for (int i = 0; i < active_leds(); i++) begin
         cmd.led         = led_tbl[i];
         cmd.red         = color_tbl[cur_step][23:16];
         cmd.green       = color_tbl[cur_step][15:8];
         cmd.blue        = color_tbl[cur_step][7:0];
         cmd.fade_ms     = fade_reg;
         cmd.step_number = cur_step;
         cmd.last        = 1'b0;
         if (staged_valid) begin
            expected_cmds.push_back(staged_cmd);
         end
         staged_cmd   = cmd;
         staged_valid = 1'b1;
      end
   endfunction

   // Updates the predicted state for one accepted item and queues its commands.
   function automatic void predict_led_commands(input pattern_item_type item);
      int n_steps;
      int moves;
      bit [MS_W-1:0] dur;
      n_steps = active_steps();
      case (item.op)
         OP_WRITE_STEP: begin
            color_tbl[item.slot]    = {item.red, item.green, item.blue};
            duration_tbl[item.slot] = item.duration_ms;
         end
         OP_WRITE_LED: begin
            led_tbl[item.slot] = item.led;
         end
         OP_START: begin
            cur_step    = '0;
            elapsed_sum = '0;
            if (n_steps != 0) begin
               stage_step_drive();
            end
         end
         OP_TICK: begin
            // With no steps in use the tick is dropped without adding time.
            if (n_steps != 0) begin
               elapsed_sum += item.tick_ms;
               moves = 0;
               while (moves < n_steps) begin
                  dur = duration_tbl[cur_step];
                  if (dur != 0 && elapsed_sum < dur) break;
                  elapsed_sum -= dur;
                  cur_step = STEP_W'((int'(cur_step) + 1) % n_steps);
                  stage_step_drive();
                  moves++;
               end
            end
         end
      endcase
      if (staged_valid) begin
         staged_cmd.last = 1'b1;
         expected_cmds.push_back(staged_cmd);
         staged_valid = 1'b0;
      end
   endfunction

   // Every field random, so that the fields an operation ignores still toggle.
   function automatic pattern_item_type noise_item();
      pattern_item_type item;
      item.op          = OP_TICK;
      item.tick_ms     = $urandom;
      item.slot        = SLOT_W'($urandom_range(0, MAX_STEPS - 1));
      item.red         = CHAN_W'($urandom);
      item.green       = CHAN_W'($urandom);
      item.blue        = CHAN_W'($urandom);
      item.duration_ms = $urandom;
      item.led         = LED_W'($urandom);
      return item;
   endfunction

   // Mostly ticks sized against the step durations, with table rewrites and
   // restarts mixed in. Rare huge values push elapsed time through its wrap.
   function automatic pattern_item_type random_item();
      pattern_item_type item;
      int pick;
      int scale;
      item  = noise_item();
      pick  = $urandom_range(0, 99);
      scale = $urandom_range(0, 9);
      if (pick < 10) begin
         item.op = OP_START;
      end else if (pick < 22) begin
         item.op = OP_WRITE_STEP;
         if (scale < 3) begin
            item.duration_ms = '0;
         end else if (scale < 8) begin
            item.duration_ms = $urandom_range(1, 40);
         end else if (scale == 8) begin
            item.duration_ms = $urandom_range(41, 1000);
         end
      end else if (pick < 30) begin
         item.op = OP_WRITE_LED;
      end else if (scale < 2) begin
         item.tick_ms = '0;
      end else if (scale < 7) begin
         item.tick_ms = $urandom_range(1, 30);
      end else if (scale < 9) begin
         item.tick_ms = $urandom_range(31, 300);
      end
      return item;
   endfunction

   // Offers one item after a random gap and predicts it once the transfer
   // has happened. Valid stays high so that the next item can follow at once.
   task automatic send_item(input pattern_item_type item);
      int gap;
      gap = pick_wait(send_calm);
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid             <= 1'b1;
      req_chan.operation         <= item.op;
      req_chan.tick_ms           <= item.tick_ms;
      req_chan.entry_slot        <= item.slot;
      req_chan.entry_red         <= item.red;
      req_chan.entry_green       <= item.green;
      req_chan.entry_blue        <= item.blue;
      req_chan.entry_duration_ms <= item.duration_ms;
      req_chan.entry_led         <= item.led;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_led_commands(item);
   endtask

   task automatic send_tick(input bit [MS_W-1:0] ms);
      pattern_item_type item;
      item         = noise_item();
      item.tick_ms = ms;
      send_item(item);
   endtask

   task automatic send_start();
      pattern_item_type item;
      item    = noise_item();
      item.op = OP_START;
      send_item(item);
   endtask

   task automatic send_step_entry(input bit [SLOT_W-1:0] slot, input bit [CHAN_W-1:0] red,
                                  input bit [CHAN_W-1:0] green, input bit [CHAN_W-1:0] blue,
                                  input bit [MS_W-1:0] duration_ms);
      pattern_item_type item;
      item             = noise_item();
      item.op          = OP_WRITE_STEP;
      item.slot        = slot;
      item.red         = red;
      item.green       = green;
      item.blue        = blue;
      item.duration_ms = duration_ms;
      send_item(item);
   endtask

   task automatic send_led_entry(input bit [SLOT_W-1:0] slot, input bit [LED_W-1:0] led);
      pattern_item_type item;
      item      = noise_item();
      item.op   = OP_WRITE_LED;
      item.slot = slot;
      item.led  = led;
      send_item(item);
   endtask

   // Stops offering items until every owed command has arrived, then lets
   // the sequencer finish any work that produces no command.
   task automatic wait_for_commands(input int settle);
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (expected_cmds.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_register(input reg_index_type index, input bit [MS_W-1:0] value);
      @(negedge clock);
      csr_chan.valid     <= 1'b1;
      csr_chan.reg_index <= index;
      csr_chan.wr_data   <= value;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      case (index)
         REG_STEPS_IN_USE: steps_reg = value[COUNT_W-1:0];
         REG_LEDS_IN_USE:  leds_reg  = value[COUNT_W-1:0];
         REG_FADE_TIME:    fade_reg  = value;
         default: ;
      endcase
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   // Idle-only register update. Upper bits of the count registers are random
   // to show that only the low nibble is kept.
   task automatic set_registers(input bit [COUNT_W-1:0] steps, input bit [COUNT_W-1:0] leds,
                                input bit [MS_W-1:0] fade);
      wait_for_commands(SETTLE_CYCLES);
      write_register(REG_STEPS_IN_USE, {28'($urandom), steps});
      write_register(REG_LEDS_IN_USE, {28'($urandom), leds});
      write_register(REG_FADE_TIME, fade);
   endtask

   task automatic run_random_phase(input int n_items, input bit [COUNT_W-1:0] steps,
                                   input bit [COUNT_W-1:0] leds, input bit [MS_W-1:0] fade,
                                   input bit hold_off);
      set_registers(steps, leds, fade);
      for (int i = 0; i < n_items; i++) begin
         if (hold_off && i == n_items / 4) begin
            rsp_hold_request = HOLD_CYCLES;
         end
         if ($urandom_range(0, 39) == 0) begin
            wait_for_commands(0);
         end
         send_item(random_item());
      end
   endtask

   // Every slot is written before anything reads it, with channel extremes.
   task automatic test_table_load();
      send_step_entry(3'd0, 8'hFF, 8'hFF, 8'hFF, 32'd5);
      send_step_entry(3'd1, 8'h00, 8'h00, 8'h00, 32'd0);
      send_step_entry(3'd2, 8'h80, 8'h7F, 8'h01, 32'd0);
      send_step_entry(3'd3, 8'hAA, 8'h55, 8'h0F, 32'd1);
      send_step_entry(3'd4, 8'h12, 8'hC3, 8'h5A, 32'hFFFF_FFFF);
      send_step_entry(3'd5, 8'($urandom), 8'($urandom), 8'($urandom), 32'd3);
      send_step_entry(3'd6, 8'($urandom), 8'($urandom), 8'($urandom), 32'd0);
      send_step_entry(3'd7, 8'h01, 8'hFE, 8'h80, 32'd2);
      send_led_entry(3'd0, 16'hFFFF);
      send_led_entry(3'd1, 16'h0000);
      for (int i = 2; i < MAX_LEDS; i++) begin
         send_led_entry(SLOT_W'(i), 16'($urandom));
      end
   endtask

   // Reset values: one step, one LED, no fade. One move per tick at most.
   task automatic test_default_registers();
      send_start();
      send_tick(32'd4);
      send_tick(32'd12);
      send_tick(32'd0);
   endtask

   // Full pattern: skipped zero-length steps, a step that only ends after
   // elapsed time wraps, and a long tick that runs around the loop.
   task automatic test_step_walk();
      set_registers(4'd8, 4'd8, 32'hFFFF_FFFF);
      send_start();
      send_tick(32'd5);
      send_tick(32'd1);
      send_tick(32'hFFFF_FFFE);
      send_tick(32'd3);
      send_tick(32'hFFFF_FFFE);
      send_tick(32'd100);
   endtask

   // No steps: ticks and starts produce nothing. No LEDs: moves still happen.
   task automatic test_zero_counts();
      set_registers(4'd0, 4'd8, 32'h0000_0001);
      send_tick(32'd50);
      send_start();
      set_registers(4'd8, 4'd0, 32'h0000_0001);
      send_tick(32'hFFFF_FFFF);
      set_registers(4'd8, 4'd8, 32'h8000_0000);
      send_tick(32'd6);
   endtask

   // Counts above the table sizes clamp; the spare register index is ignored.
   task automatic test_saturated_counts();
      wait_for_commands(SETTLE_CYCLES);
      write_register(REG_STEPS_IN_USE, 32'hFFFF_FFFF);
      write_register(REG_LEDS_IN_USE, 32'h0000_0009);
      write_register(REG_SPARE, $urandom);
      send_start();
      send_tick(32'd7);
   endtask

   // Two steps and a large tick: two moves, the rest stays for the next tick.
   task automatic test_move_limit();
      set_registers(4'd2, 4'd3, $urandom);
      send_start();
      send_tick(32'd1000);
      send_tick(32'd0);
   endtask

   task automatic test_random_patterns();
      run_random_phase(60, 4'd1, 4'd1, 32'd0, 1'b0);
      run_random_phase(70, 4'd8, 4'd8, 32'hFFFF_FFFF, 1'b0);
      run_random_phase(50, 4'd3, 4'd5, $urandom, 1'b0);
      run_random_phase(20, 4'd0, 4'd4, $urandom, 1'b0);
      run_random_phase(40, 4'd8, 4'd0, $urandom, 1'b0);
      for (int p = 0; p < 4; p++) begin
         run_random_phase(60, COUNT_W'($urandom_range(1, MAX_STEPS)),
                          COUNT_W'($urandom_range(1, MAX_LEDS)), $urandom, 1'b0);
      end
   endtask

   // The response side stops for a long stretch while ticks keep coming, so
   // the sequencer fills up and must hold off its input.
   task automatic test_output_backpressure();
      run_random_phase(60, 4'd15, 4'd15, $urandom, 1'b1);
   endtask

   // Response side: a random wait before each transfer, plus any hold-off
   // that a test asks for.
   initial begin
      int gap;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_request > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (rsp_hold_request) @(negedge clock);
            rsp_hold_request = 0;
         end
         gap = pick_wait(recv_calm);
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_chan.valid === 1'b1 && !reset)) @(posedge clock);
      end
   end

   // Compares each response transfer with the oldest owed command.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (expected_cmds.size() == 0) begin
            note_mismatch($sformatf("unexpected command: LED %0h step %0d",
                                    rsp_chan.led_number, rsp_chan.step_number));
         end else begin
            want_cmd = expected_cmds.pop_front();
            check_field("led_number", MS_W'(want_cmd.led), MS_W'(rsp_chan.led_number));
            check_field("out_red", MS_W'(want_cmd.red), MS_W'(rsp_chan.out_red));
            check_field("out_green", MS_W'(want_cmd.green), MS_W'(rsp_chan.out_green));
            check_field("out_blue", MS_W'(want_cmd.blue), MS_W'(rsp_chan.out_blue));
            check_field("fade_ms", want_cmd.fade_ms, rsp_chan.fade_ms);
            check_field("step_number", MS_W'(want_cmd.step_number),
                        MS_W'(rsp_chan.step_number));
            check_field("last", MS_W'(want_cmd.last), MS_W'(rsp_chan.last));
         end
      end
   end

   // Ends the run when no transfer of any kind happens for too long.
   always @(posedge clock) begin
      if (reset || (req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
          (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) ||
          (csr_chan.valid === 1'b1 && csr_chan.ready === 1'b1)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timed_color_step_sequencer_tb NOT OK");
            $finish;
         end
      end
   end

   initial begin
      req_chan.valid             = 1'b0;
      req_chan.operation         = OP_TICK;
      req_chan.tick_ms           = '0;
      req_chan.entry_slot        = '0;
      req_chan.entry_red         = '0;
      req_chan.entry_green       = '0;
      req_chan.entry_blue        = '0;
      req_chan.entry_duration_ms = '0;
      req_chan.entry_led         = '0;
      csr_chan.valid             = 1'b0;
      csr_chan.reg_index         = REG_STEPS_IN_USE;
      csr_chan.wr_data           = '0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_table_load();
      test_default_registers();
      test_step_walk();
      test_zero_counts();
      test_saturated_counts();
      test_move_limit();
      test_random_patterns();
      test_output_backpressure();

      wait_for_commands(SETTLE_CYCLES);
      if (mismatches == 0) begin
         $display("timed_color_step_sequencer_tb OK");
      end else begin
         $display("timed_color_step_sequencer_tb NOT OK");
      end
      $finish;
   end

endmodule
